/* sv/cubic_bezier_point_evaluator_assert.svh */
// assertion macros for the cubic bezier point evaluator checker
// no dependencies; included by the checker file
`ifndef CUBIC_BEZIER_POINT_EVALUATOR_ASSERT_SVH
`define CUBIC_BEZIER_POINT_EVALUATOR_ASSERT_SVH

// same-cycle implication
`define CBPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cbpe check failed: same-cycle implication");

// next-cycle implication
`define CBPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cbpe check failed: next-cycle implication");

`endif

/* sv/cbpe_pkg.sv */
// shared types, widths and the sample-to-t table for the cubic bezier evaluator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cbpe_pkg;

	localparam int unsigned STEPS      = 100;
	localparam int unsigned INDEX_W    = 7;
	localparam int unsigned INDEX_SPAN = 1 << INDEX_W;
	localparam int unsigned FRAC       = 16;
	localparam int unsigned T_W        = 16;
	localparam int unsigned U_W        = 17;
	localparam int unsigned W_W        = 17;
	localparam int unsigned COORD_W    = 16;
	localparam int unsigned PROD_W     = W_W + 1 + COORD_W;
	localparam int unsigned ACC_W      = PROD_W + 2;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_START_X = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULL1_X = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PULL1_Y = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PULL2_X = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PULL2_Y = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_END_X   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 4'd7;

	typedef logic [INDEX_SPAN-1:0][T_W-1:0] t_lut_t;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
		logic ld_s6;
	} cbpe_ctl_t;

	typedef struct packed {
		logic [W_W-1:0] w0;
		logic [W_W-1:0] w1;
		logic [W_W-1:0] w2;
		logic [W_W-1:0] w3;
	} cbpe_wt_t;

	// t = floor(k * 2^16 / STEPS), index clamped to STEPS-1
	function automatic t_lut_t build_t_lut();
		t_lut_t lut;
		longint unsigned k;
		for (int i = 0; i < INDEX_SPAN; i++) begin
			k = (i < STEPS) ? longint'(i) : longint'(STEPS - 1);
			lut[i] = T_W'((k << FRAC) / STEPS);
		end
		return lut;
	endfunction

	localparam t_lut_t T_LUT = build_t_lut();

endpackage

`default_nettype wire

/* sv/cbpe_weights.sv */
// bernstein weight pipeline: t lookup, squares, cubic weights (stages 1 to 3)
// depends on cbpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbpe_weights import cbpe_pkg::*; (
	input  wire logic                 clk,
	input  wire cbpe_ctl_t            ctl,
	input  wire logic [INDEX_W-1:0]   sample_index,
	output cbpe_wt_t                  wt
);

	localparam logic [U_W-1:0] ONE_Q16 = U_W'(1) << FRAC;

	logic [T_W-1:0] t_s1;
	logic [U_W-1:0] u_s1;
	logic [T_W-1:0] t_s2;
	logic [U_W-1:0] u_s2;
	logic [U_W-1:0] u2_s2;
	logic [T_W-1:0] t2_s2;
	cbpe_wt_t       wt_s3;

	logic [T_W-1:0]   t_lk;
	logic [2*U_W-1:0] uu;
	logic [2*T_W-1:0] tt;
	logic [U_W+1:0]   u2x3;
	logic [U_W+1:0]   ux3;
	logic [2*U_W-1:0] p0;
	logic [U_W+T_W+1:0] p1;
	logic [U_W+T_W+1:0] p2;
	logic [2*T_W-1:0] p3;

	assign t_lk = T_LUT[sample_index];
	assign uu   = u_s1 * u_s1;
	assign tt   = t_s1 * t_s1;
	assign u2x3 = (U_W+2)'({u2_s2, 1'b0}) + (U_W+2)'(u2_s2);
	assign ux3  = (U_W+2)'({u_s2, 1'b0}) + (U_W+2)'(u_s2);
	assign p0   = u2_s2 * u_s2;
	assign p1   = u2x3 * t_s2;
	assign p2   = ux3 * t2_s2;
	assign p3   = t2_s2 * t_s2;

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			t_s1 <= t_lk;
			u_s1 <= ONE_Q16 - U_W'(t_lk);
		end
		if (ctl.ld_s2) begin
			t_s2  <= t_s1;
			u_s2  <= u_s1;
			u2_s2 <= uu[FRAC +: U_W];
			t2_s2 <= tt[FRAC +: T_W];
		end
		if (ctl.ld_s3) begin
			wt_s3.w0 <= p0[FRAC +: W_W];
			wt_s3.w1 <= p1[FRAC +: W_W];
			wt_s3.w2 <= p2[FRAC +: W_W];
			wt_s3.w3 <= W_W'(p3[2*T_W-1:FRAC]);
		end
	end

	assign wt = wt_s3;

endmodule

`default_nettype wire

/* sv/cbpe_blend.sv */
// one coordinate: weighted control points, sum, truncate and saturate (stages 4 to 6)
// depends on cbpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbpe_blend import cbpe_pkg::*; (
	input  wire logic                      clk,
	input  wire cbpe_ctl_t                 ctl,
	input  wire cbpe_wt_t                  wt,
	input  wire logic signed [COORD_W-1:0] p0,
	input  wire logic signed [COORD_W-1:0] p1,
	input  wire logic signed [COORD_W-1:0] p2,
	input  wire logic signed [COORD_W-1:0] p3,
	output logic signed [COORD_W-1:0]      coord
);

	localparam logic signed [ACC_W-1:0] BIAS   = ACC_W'((1 << FRAC) - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (COORD_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1 << (COORD_W - 1)));

	logic signed [PROD_W-1:0]  m0_s4;
	logic signed [PROD_W-1:0]  m1_s4;
	logic signed [PROD_W-1:0]  m2_s4;
	logic signed [PROD_W-1:0]  m3_s4;
	logic signed [ACC_W-1:0]   acc_s5;
	logic signed [COORD_W-1:0] coord_s6;

	logic signed [ACC_W-1:0] acc_adj;
	logic signed [ACC_W-1:0] quo;

	// truncate toward zero
	assign acc_adj = acc_s5 + (acc_s5[ACC_W-1] ? BIAS : '0);
	assign quo     = acc_adj >>> FRAC;

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			m0_s4 <= $signed({1'b0, wt.w0}) * p0;
			m1_s4 <= $signed({1'b0, wt.w1}) * p1;
			m2_s4 <= $signed({1'b0, wt.w2}) * p2;
			m3_s4 <= $signed({1'b0, wt.w3}) * p3;
		end
		if (ctl.ld_s5) begin
			acc_s5 <= ACC_W'(m0_s4) + ACC_W'(m1_s4) + ACC_W'(m2_s4) + ACC_W'(m3_s4);
		end
		if (ctl.ld_s6) begin
			priority if (quo > SAT_HI) begin
				coord_s6 <= SAT_HI[COORD_W-1:0];
			end else if (quo < SAT_LO) begin
				coord_s6 <= SAT_LO[COORD_W-1:0];
			end else begin
				coord_s6 <= quo[COORD_W-1:0];
			end
		end
	end

	assign coord = coord_s6;

endmodule

`default_nettype wire

/* sv/cubic_bezier_point_evaluator.sv */
// cubic bezier point evaluator top level: control point registers, stage control
// depends on cbpe_pkg, cbpe_weights, cbpe_blend
//
// usage:
//   configuration: cfg_we writes cfg_data[15:0] into the control point register
//   selected by cfg_index (0 start_x, 1 start_y, 2 pull1_x, 3 pull1_y, 4 pull2_x,
//   5 pull2_y, 6 end_x, 7 end_y); other indexes are ignored. write only while idle.
//   input channel: in_valid/in_ready carry sample_index k, t = k/100, k above 99
//   is treated as 99.
//   output channel: out_valid/out_ready carry curve_x and curve_y, the curve point
//   truncated toward zero and saturated to 16 bits.
//   pipeline: an accepted item passes through six register stages (t lookup,
//   squares, weights, products, sum, round) before it shows on the outputs.
//   throughput: one item per cycle unless stalled; stage 4 holds eight 18x16 multipliers.
//   stall: each stage takes a new item when it is empty or its successor moves,
//   so bubbles close up; while a result waits at the output the block still
//   accepts as long as some stage is empty, and holds in_ready low once all six are full.
//   reset: arst_n clears all stage valid bits and the control points to zero.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_point_evaluator import cbpe_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [INDEX_W-1:0]          sample_index,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [COORD_W-1:0]        curve_x,
	output logic signed [COORD_W-1:0]        curve_y
);

	logic signed [COORD_W-1:0] start_x_q;
	logic signed [COORD_W-1:0] start_y_q;
	logic signed [COORD_W-1:0] pull1_x_q;
	logic signed [COORD_W-1:0] pull1_y_q;
	logic signed [COORD_W-1:0] pull2_x_q;
	logic signed [COORD_W-1:0] pull2_y_q;
	logic signed [COORD_W-1:0] end_x_q;
	logic signed [COORD_W-1:0] end_y_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	cbpe_ctl_t ctl;
	cbpe_wt_t  wt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			pull1_x_q <= '0;
			pull1_y_q <= '0;
			pull2_x_q <= '0;
			pull2_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_X: start_x_q <= cfg_data[COORD_W-1:0];
				REG_START_Y: start_y_q <= cfg_data[COORD_W-1:0];
				REG_PULL1_X: pull1_x_q <= cfg_data[COORD_W-1:0];
				REG_PULL1_Y: pull1_y_q <= cfg_data[COORD_W-1:0];
				REG_PULL2_X: pull2_x_q <= cfg_data[COORD_W-1:0];
				REG_PULL2_Y: pull2_y_q <= cfg_data[COORD_W-1:0];
				REG_END_X:   end_x_q   <= cfg_data[COORD_W-1:0];
				REG_END_Y:   end_y_q   <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// a stage moves when empty or when its successor moves
	assign rdy6 = !v_s6 || out_ready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign ctl.ld_s1 = rdy1 && in_valid;
	assign ctl.ld_s2 = rdy2 && v_s1;
	assign ctl.ld_s3 = rdy3 && v_s2;
	assign ctl.ld_s4 = rdy4 && v_s3;
	assign ctl.ld_s5 = rdy5 && v_s4;
	assign ctl.ld_s6 = rdy6 && v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
			if (rdy6) begin
				v_s6 <= v_s5;
			end
		end
	end

	cbpe_weights u_weights (
		.clk          (clk),
		.ctl          (ctl),
		.sample_index (sample_index),
		.wt           (wt)
	);

	cbpe_blend u_blend_x (
		.clk   (clk),
		.ctl   (ctl),
		.wt    (wt),
		.p0    (start_x_q),
		.p1    (pull1_x_q),
		.p2    (pull2_x_q),
		.p3    (end_x_q),
		.coord (curve_x)
	);

	cbpe_blend u_blend_y (
		.clk   (clk),
		.ctl   (ctl),
		.wt    (wt),
		.p0    (start_y_q),
		.p1    (pull1_y_q),
		.p2    (pull2_y_q),
		.p3    (end_y_q),
		.coord (curve_y)
	);

	assign in_ready  = rdy1;
	assign out_valid = v_s6;

endmodule

`default_nettype wire

/* sv/cbpe_checker.sv */
// port-level checks for the cubic bezier point evaluator, bound to the top level
// depends on cbpe_pkg and cubic_bezier_point_evaluator_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "cubic_bezier_point_evaluator_assert.svh"

module cbpe_checker import cbpe_pkg::*; (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic [INDEX_W-1:0]          sample_index,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic signed [COORD_W-1:0]   curve_x,
	input wire logic signed [COORD_W-1:0]   curve_y
);

	// stalled item stays and holds its value
	`CBPE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(curve_x) && $stable(curve_y))

	// an empty output stage means nothing can block the input
	`CBPE_ASSERT_NOW(a_empty_ready, clk, arst_n, !out_valid, in_ready)

	// a draining output frees every stage behind it
	`CBPE_ASSERT_NOW(a_drain_ready, clk, arst_n, out_ready, in_ready)

	// a waiting input item stays and holds its index
	`CBPE_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(sample_index))

endmodule

bind cubic_bezier_point_evaluator cbpe_checker u_cbpe_checker (.*);

`default_nettype wire
